// File: rtl/wdc_pkg.sv
// Shared types and constants of the window displacement cost block.
`default_nettype none

package wdc_pkg;

   // Field widths fixed by the request and result formats.
   localparam int ELEV_BITS       = 16;
   localparam int COST_BITS       = 32;
   localparam int FRAME_DIM_BITS  = 13;
   localparam int HEIGHT_LIMIT    = 4096;

   // Window geometry: three taps per side, nine labels.
   localparam int WIN_SIDE   = 3;
   localparam int NUM_TAPS   = 9;
   localparam int CENTRE_TAP = 4;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOUNDARY_COST = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COST_SHAPE    = 2'd3;

   localparam logic [FRAME_DIM_BITS-1:0] FRAME_WIDTH_RESET   = 13'd1024;
   localparam logic [FRAME_DIM_BITS-1:0] FRAME_HEIGHT_RESET  = 13'd1024;
   localparam logic [COST_BITS-1:0]      BOUNDARY_COST_RESET = 32'd65535;

   // Cost shapes.
   localparam logic SHAPE_SQUARED  = 1'b0;
   localparam logic SHAPE_ABS_DIFF = 1'b1;

   // Request kinds.
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   typedef struct packed {
      logic                        kind;
      logic signed [ELEV_BITS-1:0] elevation;
      logic                        bad;
   } req_type;

   typedef struct packed {
      logic [COST_BITS-1:0] cost_up_left;
      logic [COST_BITS-1:0] cost_up;
      logic [COST_BITS-1:0] cost_up_right;
      logic [COST_BITS-1:0] cost_left;
      logic [COST_BITS-1:0] cost_centre;
      logic [COST_BITS-1:0] cost_right;
      logic [COST_BITS-1:0] cost_down_left;
      logic [COST_BITS-1:0] cost_down;
      logic [COST_BITS-1:0] cost_down_right;
      logic                 last_of_frame;
   } rsp_type;

   // One stored sample of the line stores and the window.
   typedef struct packed {
      logic                        bad;
      logic signed [ELEV_BITS-1:0] elev;
   } store_entry_type;

endpackage

`default_nettype wire

// File: rtl/wdc_ram.sv
// Simple dual-port RAM with one write port and one registered read-first read port.
`default_nettype none

module wdc_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents when both ports hit the same address.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/window_displacement_cost_top.sv
// Top level of the 3x3 window displacement cost generator.
//
// Usage:
//  - Requests carry one elevation pixel each, in raster order, on req_valid / req_ready.
//    After each frame, send frame_width+1 flush requests to drain the window.
//  - The result for a pixel (nine label costs and last_of_frame) is produced by the
//    request that arrives one row and one column after it; requests that complete no
//    centre produce nothing.
//  - A result reaches rsp_valid through stages A to D and the result register once the
//    request that completes it is accepted. Throughput: one request per cycle unless
//    stalled, set by the two line stores, each a RAM read and written once per request.
//  - Configuration goes through csr_wr_en / csr_index / csr_wdata while the block is
//    idle; writing the frame width or height restarts the frame position.
//  - Reset loads the register defaults and zeroes the frame position. The line stores
//    are not cleared: taps that fall outside the frame always take the boundary cost,
//    so stale contents never reach a result.
//  - When the receiver stalls, the whole pipeline holds and req_ready drops in the
//    same cycle; no result is lost or repeated.
`default_nettype none

module window_displacement_cost_top #(
   parameter int MAX_WIDTH = 4096
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_ready,
   input  wire wdc_pkg::req_type                     req_data,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   output      wdc_pkg::rsp_type                     rsp_data,
   input  wire logic                                 csr_wr_en,
   input  wire logic [wdc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [wdc_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   import wdc_pkg::*;

   localparam int COL_BITS     = $clog2(MAX_WIDTH);
   localparam int WIDTH_BITS   = $clog2(MAX_WIDTH + 1);
   localparam int ROW_BITS     = FRAME_DIM_BITS;
   localparam int ROW_EXT_BITS = FRAME_DIM_BITS + 1;
   localparam int DIFF_BITS    = ELEV_BITS + 1;
   localparam int SQ_BITS      = 2 * ELEV_BITS;
   localparam int ENTRY_BITS   = $bits(store_entry_type);

   // Position of the centre completed by a request, and which frame edges it touches.
   typedef struct packed {
      logic emit;
      logic last;
      logic left_edge;
      logic right_edge;
      logic top_edge;
      logic bottom_edge;
   } win_ctl_type;

   // ---------------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------------
   logic [FRAME_DIM_BITS-1:0] frame_width_ff;
   logic [FRAME_DIM_BITS-1:0] frame_height_ff;
   logic [COST_BITS-1:0]      boundary_cost_ff;
   logic                      cost_shape_ff;
   logic                      restart_frame;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= FRAME_WIDTH_RESET;
         frame_height_ff  <= FRAME_HEIGHT_RESET;
         boundary_cost_ff <= BOUNDARY_COST_RESET;
         cost_shape_ff    <= SHAPE_SQUARED;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               frame_width_ff <= csr_wdata[FRAME_DIM_BITS-1:0];
            end
            CSR_FRAME_HEIGHT: begin
               frame_height_ff <= csr_wdata[FRAME_DIM_BITS-1:0];
            end
            CSR_BOUNDARY_COST: begin
               boundary_cost_ff <= csr_wdata[COST_BITS-1:0];
            end
            CSR_COST_SHAPE: begin
               cost_shape_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // A width or height write restarts the frame position.
   assign restart_frame = csr_wr_en &&
                          ((csr_index == CSR_FRAME_WIDTH) || (csr_index == CSR_FRAME_HEIGHT));

   // Clamp the frame size to the line store depth and the height limit; zero counts as one.
   logic [WIDTH_BITS-1:0]     width_eff;
   logic [FRAME_DIM_BITS-1:0] height_eff;

   always_comb begin
      if (frame_width_ff == '0) begin
         width_eff = WIDTH_BITS'(1);
      end else if (32'(frame_width_ff) > 32'(MAX_WIDTH)) begin
         width_eff = WIDTH_BITS'(MAX_WIDTH);
      end else begin
         width_eff = WIDTH_BITS'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         height_eff = FRAME_DIM_BITS'(1);
      end else if (32'(frame_height_ff) > 32'(HEIGHT_LIMIT)) begin
         height_eff = FRAME_DIM_BITS'(HEIGHT_LIMIT);
      end else begin
         height_eff = frame_height_ff;
      end
   end

   // ---------------------------------------------------------------------------------
   // Handshake: every stage advances together whenever the result register is free.
   // ---------------------------------------------------------------------------------
   logic rsp_valid_ff;
   logic advance;
   logic req_accept;

   assign advance    = !rsp_valid_ff || rsp_ready;
   assign req_ready  = advance;
   assign req_accept = req_valid && advance;

   // ---------------------------------------------------------------------------------
   // Stream position of the incoming request
   // ---------------------------------------------------------------------------------
   logic [COL_BITS-1:0]     col_ff, col_in;
   logic [ROW_BITS-1:0]     row_ff, row_in;
   logic [WIDTH_BITS-1:0]   col_inc;
   logic [ROW_EXT_BITS-1:0] row_ext, row_next, height_p1, height_p2;
   logic                    col_nonzero;
   win_ctl_type             a_ctl_in;

   assign col_inc     = WIDTH_BITS'(col_ff) + WIDTH_BITS'(1);
   assign row_ext     = ROW_EXT_BITS'(row_ff);
   assign height_p1   = ROW_EXT_BITS'(height_eff) + ROW_EXT_BITS'(1);
   assign height_p2   = ROW_EXT_BITS'(height_eff) + ROW_EXT_BITS'(2);
   assign col_nonzero = (col_ff != '0);

   // At column zero the completed centre is the end of the row two rows back,
   // otherwise it is the previous column one row back.
   always_comb begin
      if (col_nonzero) begin
         a_ctl_in.emit        = (row_ext >= ROW_EXT_BITS'(1)) &&
                                (row_ext <= ROW_EXT_BITS'(height_eff));
         a_ctl_in.left_edge   = (col_ff == COL_BITS'(1));
         a_ctl_in.top_edge    = (row_ext == ROW_EXT_BITS'(1));
         a_ctl_in.bottom_edge = (row_ext == ROW_EXT_BITS'(height_eff));
      end else begin
         a_ctl_in.emit        = (row_ext >= ROW_EXT_BITS'(2)) && (row_ext <= height_p1);
         a_ctl_in.left_edge   = (width_eff == WIDTH_BITS'(1));
         a_ctl_in.top_edge    = (row_ext == ROW_EXT_BITS'(2));
         a_ctl_in.bottom_edge = (row_ext == height_p1);
      end
      a_ctl_in.right_edge = !col_nonzero;
      a_ctl_in.last       = a_ctl_in.emit && !col_nonzero && (row_ext == height_p1);
   end

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      row_next = row_ext;
      if (a_ctl_in.last) begin
         col_in = '0;
         row_in = '0;
      end else begin
         if (col_inc == width_eff) begin
            col_in   = '0;
            row_next = row_ext + ROW_EXT_BITS'(1);
         end else begin
            col_in = COL_BITS'(col_inc);
         end
         if (row_next > height_p2) begin
            col_in = '0;
            row_in = '0;
         end else begin
            row_in = ROW_BITS'(row_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart_frame) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Flush requests enter the window as bad samples of zero elevation.
   store_entry_type entry_in;

   always_comb begin
      if (req_data.kind == KIND_FLUSH) begin
         entry_in.elev = '0;
         entry_in.bad  = 1'b1;
      end else begin
         entry_in.elev = req_data.elevation;
         entry_in.bad  = req_data.bad;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage A: first line store, one row of delay, addressed by column
   // ---------------------------------------------------------------------------------
   logic                a_valid_ff;
   store_entry_type     a_entry_ff;
   logic [COL_BITS-1:0] a_col_ff;
   win_ctl_type         a_ctl_ff;
   store_entry_type     line1_q;

   wdc_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line1 (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (col_ff),
      .wr_data (entry_in),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (line1_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_entry_ff <= entry_in;
         a_col_ff   <= col_ff;
         a_ctl_ff   <= a_ctl_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage B: second line store fed from the first, two rows of delay
   // ---------------------------------------------------------------------------------
   logic            b_valid_ff;
   store_entry_type b_entry_ff;
   store_entry_type b_up_ff;
   win_ctl_type     b_ctl_ff;
   store_entry_type line2_q;
   logic            a_step;

   assign a_step = advance && a_valid_ff;

   wdc_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line2 (
      .clock   (clock),
      .wr_en   (a_step),
      .wr_addr (a_col_ff),
      .wr_data (line1_q),
      .rd_en   (a_step),
      .rd_addr (a_col_ff),
      .rd_data (line2_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_step) begin
         b_entry_ff <= a_entry_ff;
         b_up_ff    <= line1_q;
         b_ctl_ff   <= a_ctl_ff;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage C: 3x3 window, shifted once per request.
   // Taps 6..8 hold the newest row, 3..5 the row above, 0..2 the row two above.
   // ---------------------------------------------------------------------------------
   logic            c_valid_ff;
   win_ctl_type     c_ctl_ff;
   store_entry_type win_ff [NUM_TAPS];
   logic            b_step;

   assign b_step = advance && b_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_step) begin
         win_ff[8] <= b_entry_ff;
         win_ff[7] <= win_ff[8];
         win_ff[6] <= win_ff[7];
         win_ff[5] <= b_up_ff;
         win_ff[4] <= win_ff[5];
         win_ff[3] <= win_ff[4];
         win_ff[2] <= line2_q;
         win_ff[1] <= win_ff[2];
         win_ff[0] <= win_ff[1];
         c_ctl_ff  <= b_ctl_ff;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage D: absolute differences against the centre, and boundary flags
   // ---------------------------------------------------------------------------------
   logic                 d_valid_ff;
   logic                 d_last_ff;
   logic [ELEV_BITS-1:0] d_abs_ff   [NUM_TAPS];
   logic                 d_bound_ff [NUM_TAPS];
   logic [ELEV_BITS-1:0] d_abs_in   [NUM_TAPS];
   logic                 d_bound_in [NUM_TAPS];
   logic [DIFF_BITS-1:0] diff       [NUM_TAPS];
   logic [DIFF_BITS-1:0] centre_ext;

   assign centre_ext = {win_ff[CENTRE_TAP].elev[ELEV_BITS-1], win_ff[CENTRE_TAP].elev};

   always_comb begin
      for (int k = 0; k < WIN_SIDE; k++) begin
         for (int l = 0; l < WIN_SIDE; l++) begin
            diff[k*WIN_SIDE+l] = centre_ext -
               {win_ff[k*WIN_SIDE+l].elev[ELEV_BITS-1], win_ff[k*WIN_SIDE+l].elev};
            if (diff[k*WIN_SIDE+l][DIFF_BITS-1]) begin
               d_abs_in[k*WIN_SIDE+l] =
                  ELEV_BITS'((~diff[k*WIN_SIDE+l]) + DIFF_BITS'(1));
            end else begin
               d_abs_in[k*WIN_SIDE+l] = ELEV_BITS'(diff[k*WIN_SIDE+l]);
            end
            // Outside the frame or a bad neighbour: boundary cost.
            d_bound_in[k*WIN_SIDE+l] =
               ((l == 0)            && c_ctl_ff.left_edge)  ||
               ((l == WIN_SIDE - 1) && c_ctl_ff.right_edge) ||
               ((k == 0)            && c_ctl_ff.top_edge)   ||
               ((k == WIN_SIDE - 1) && c_ctl_ff.bottom_edge) ||
               win_ff[k*WIN_SIDE+l].bad;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (advance) begin
         d_valid_ff <= c_valid_ff && c_ctl_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_abs_ff   <= d_abs_in;
         d_bound_ff <= d_bound_in;
         d_last_ff  <= c_ctl_ff.last;
      end
   end

   // ---------------------------------------------------------------------------------
   // Result register: select boundary, absolute or saturated squared cost
   // ---------------------------------------------------------------------------------
   logic [COST_BITS-1:0] cost [NUM_TAPS];
   logic [SQ_BITS-1:0]   sq   [NUM_TAPS];
   rsp_type              rsp_data_ff, rsp_data_in;

   always_comb begin
      for (int i = 0; i < NUM_TAPS; i++) begin
         sq[i] = SQ_BITS'(d_abs_ff[i]) * SQ_BITS'(d_abs_ff[i]);
         if (d_bound_ff[i]) begin
            cost[i] = boundary_cost_ff;
         end else if (cost_shape_ff == SHAPE_ABS_DIFF) begin
            cost[i] = COST_BITS'(d_abs_ff[i]);
         end else if ((SQ_BITS > COST_BITS) && ((sq[i] >> COST_BITS) != '0)) begin
            cost[i] = '1;
         end else begin
            cost[i] = COST_BITS'(sq[i]);
         end
      end
      rsp_data_in.cost_up_left    = cost[0];
      rsp_data_in.cost_up         = cost[1];
      rsp_data_in.cost_up_right   = cost[2];
      rsp_data_in.cost_left       = cost[3];
      rsp_data_in.cost_centre     = cost[4];
      rsp_data_in.cost_right      = cost[5];
      rsp_data_in.cost_down_left  = cost[6];
      rsp_data_in.cost_down       = cost[7];
      rsp_data_in.cost_down_right = cost[8];
      rsp_data_in.last_of_frame   = d_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= d_valid_ff;
      end
   end

   // Hold the result while the receiver stalls.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: tb/window_displacement_cost_top_tb.sv
// Self-checking testbench of the 3x3 window displacement cost generator.
module window_displacement_cost_top_tb;
   import wdc_pkg::*;

   localparam int MAX_WIDTH     = 4096;
   localparam int STORE_DEPTH   = 2 * MAX_WIDTH + 3;
   localparam int RANDOM_ITEMS  = 820;
   localparam int CLAMP_ITEMS   = 64;
   localparam int DRAIN_CYCLES  = 16;
   localparam int MAX_REPORTS   = 10;
   localparam int TIMEOUT_UNITS = 4000000;

   logic                      clock;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // Traffic shaping, in percent: sender idle cycles and receiver stall cycles.
   int idle_pct  = 0;
   int stall_pct = 0;

   // Predictor state: stream history, frame position and register copies.
   store_entry_type            sample_history [STORE_DEPTH];
   int                         history_ptr = 0;
   int                         col_pos     = 0;
   int                         row_pos     = 0;
   logic [FRAME_DIM_BITS-1:0]  cfg_width    = FRAME_WIDTH_RESET;
   logic [FRAME_DIM_BITS-1:0]  cfg_height   = FRAME_HEIGHT_RESET;
   logic [COST_BITS-1:0]       cfg_boundary = BOUNDARY_COST_RESET;
   logic                       cfg_shape    = SHAPE_SQUARED;

   // Label costs still owed by the block, oldest first.
   rsp_type pending_costs [$];
   int      mismatch_count = 0;
   int      result_index   = 0;

   window_displacement_cost_top #(.MAX_WIDTH(MAX_WIDTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Stall the receiver at random; a zero percentage keeps ready high throughout.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Advance the predictor by one accepted request and queue the costs it completes.
   task automatic predict_costs(input req_type r);
      store_entry_type                      entry;
      store_entry_type                      taps [NUM_TAPS];
      logic [0:NUM_TAPS-1][COST_BITS-1:0]   label_cost;
      int                                   cols, rows, col_centre, row_centre;
      int                                   nrow, ncol, back;
      longint                               gap, magnitude, cost;
      logic                                 at_last;
      // Clamp the frame size: zero counts as one, oversize to the limits.
      cols = (cfg_width == 0) ? 1 : (cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width);
      rows = (cfg_height == 0) ? 1 :
             (cfg_height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : int'(cfg_height);
      // A flush request is stored as a bad pixel of elevation zero.
      if (r.kind == KIND_FLUSH) begin
         entry.bad  = 1'b1;
         entry.elev = '0;
      end else begin
         entry.bad  = r.bad;
         entry.elev = r.elevation;
      end
      sample_history[history_ptr] = entry;
      // The centre trails the incoming request by one row and one column.
      if (col_pos >= 1) begin
         col_centre = col_pos - 1;
         row_centre = row_pos - 1;
      end else begin
         col_centre = cols - 1;
         row_centre = row_pos - 2;
      end
      at_last = 1'b0;
      if (row_centre >= 0 && row_centre < rows && col_centre >= 0 && col_centre < cols) begin
         for (int k = 0; k < NUM_TAPS; k++) begin
            back    = (2 - k / WIN_SIDE) * cols + (2 - k % WIN_SIDE);
            taps[k] = sample_history[(history_ptr + STORE_DEPTH - back) % STORE_DEPTH];
         end
         for (int k = 0; k < NUM_TAPS; k++) begin
            nrow = row_centre + k / WIN_SIDE - 1;
            ncol = col_centre + k % WIN_SIDE - 1;
            if (nrow < 0 || nrow >= rows || ncol < 0 || ncol >= cols || taps[k].bad) begin
               label_cost[k] = cfg_boundary;
            end else begin
               gap       = longint'(taps[CENTRE_TAP].elev) - longint'(taps[k].elev);
               magnitude = (gap < 0) ? -gap : gap;
               cost      = (cfg_shape == SHAPE_ABS_DIFF) ? magnitude : magnitude * magnitude;
               // Saturate anything wider than a cost word.
               label_cost[k] = (cost > 64'h0000_0000_FFFF_FFFF) ? '1 : cost[COST_BITS-1:0];
            end
         end
         at_last = (row_centre == rows - 1) && (col_centre == cols - 1);
         pending_costs.insert(pending_costs.size(), rsp_type'({label_cost, at_last}));
      end
      history_ptr = (history_ptr + 1) % STORE_DEPTH;
      if (at_last) begin
         // The final pixel's result closes the frame; the next request opens a new one.
         col_pos = 0;
         row_pos = 0;
      end else begin
         col_pos++;
         if (col_pos >= cols) begin
            col_pos = 0;
            row_pos++;
         end
         if (row_pos > rows + 2) begin
            col_pos = 0;
            row_pos = 0;
         end
      end
   endtask

   // Present one request, hold it until accepted, then feed it to the predictor.
   task automatic push_request(input req_type r);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      predict_costs(r);
   endtask

   function automatic req_type pixel_request(input int elevation, input logic bad);
      req_type r;
      r.kind      = KIND_PIXEL;
      r.elevation = elevation[ELEV_BITS-1:0];
      r.bad       = bad;
      return r;
   endfunction

   // Randomise the data bits of a flush request: the block must ignore them.
   function automatic req_type flush_request();
      req_type r;
      r      = pixel_request($urandom, 1'($urandom_range(0, 1)));
      r.kind = KIND_FLUSH;
      return r;
   endfunction

   // Write one register; the predictor takes it at the same edge as the block.
   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_FRAME_WIDTH: begin
            cfg_width = value[FRAME_DIM_BITS-1:0];
            col_pos   = 0;
            row_pos   = 0;
         end
         CSR_FRAME_HEIGHT: begin
            cfg_height = value[FRAME_DIM_BITS-1:0];
            col_pos    = 0;
            row_pos    = 0;
         end
         CSR_BOUNDARY_COST: cfg_boundary = value[COST_BITS-1:0];
         CSR_COST_SHAPE:    cfg_shape    = value[0];
         default: ;
      endcase
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_traffic(input int sender_idle, input int receiver_stall);
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
   endtask

   // Drop valid, wait for every owed result, then let the pipeline run dry.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_costs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Send one frame of random pixels and its drain tail, cut short after stop_after.
   task automatic push_random_frame(input int cols, input int rows, input int stop_after,
                                    output int sent);
      int      total, style, base, elevation;
      req_type r;
      total = cols * rows + cols + 1;
      style = $urandom_range(0, 2);
      base  = $urandom;
      sent  = 0;
      for (int idx = 0; idx < total && idx < stop_after; idx++) begin
         if ((idx < cols * rows && $urandom_range(0, 19) != 0) ||
             (idx >= cols * rows && $urandom_range(0, 1) == 0)) begin
            case (style)
               0: elevation = $urandom;
               1: elevation = base + $urandom_range(0, 64) - 32;
               default: begin
                  case ($urandom_range(0, 3))
                     0: elevation = 32767;
                     1: elevation = -32768;
                     2: elevation = 0;
                     default: elevation = -1;
                  endcase
               end
            endcase
            r = pixel_request(elevation, $urandom_range(0, 7) == 0);
         end else begin
            r = flush_request();
         end
         push_request(r);
         sent++;
      end
   endtask

   // Reset register values for cost and shape; only the frame size is changed.
   task automatic test_default_costs();
      int samples [6] = '{10, -20, 30, 0, 5, 7};
      set_traffic(0, 0);
      write_register(CSR_FRAME_WIDTH, 32'd3);
      write_register(CSR_FRAME_HEIGHT, 32'd2);
      foreach (samples[i]) push_request(pixel_request(samples[i], 1'b0));
      repeat (4) push_request(flush_request());
      settle();
   endtask

   // Full-scale elevations, bad centres and neighbours, a flush inside the frame
   // and pixel requests in the drain tail.
   task automatic test_elevation_extremes();
      int   samples [9]   = '{32767, -32768, 0, -32768, 32767, 0, 1, -1, -32768};
      logic bad_flags [9] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
      set_traffic(27, 27);
      write_register(CSR_BOUNDARY_COST, 32'hFFFF_FFFF);
      write_register(CSR_COST_SHAPE, {31'd0, SHAPE_SQUARED});
      write_register(CSR_FRAME_WIDTH, 32'd3);
      write_register(CSR_FRAME_HEIGHT, 32'd3);
      foreach (samples[i]) begin
         if (i == 5) push_request(flush_request());
         else push_request(pixel_request(samples[i], bad_flags[i]));
      end
      push_request(pixel_request(123, 1'b0));
      push_request(flush_request());
      push_request(flush_request());
      push_request(pixel_request(-5, 1'b1));
      settle();
   endtask

   // Absolute difference with a zero boundary cost; junk above the shape bit.
   task automatic test_absolute_shape();
      int samples [4] = '{-32768, 32767, 100, -100};
      set_traffic(52, 0);
      write_register(CSR_COST_SHAPE, 32'hFFFF_FFFF);
      write_register(CSR_BOUNDARY_COST, 32'd0);
      write_register(CSR_FRAME_WIDTH, 32'd2);
      write_register(CSR_FRAME_HEIGHT, 32'd2);
      foreach (samples[i]) push_request(pixel_request(samples[i], 1'b0));
      repeat (3) push_request(flush_request());
      settle();
   endtask

   // Zero width and height count as one; single-column and single-row frames.
   task automatic test_degenerate_sizes();
      int sent;
      set_traffic(0, 52);
      write_register(CSR_BOUNDARY_COST, 32'h1234_5678);
      write_register(CSR_FRAME_WIDTH, 32'd0);
      write_register(CSR_FRAME_HEIGHT, 32'd0);
      push_request(pixel_request(1234, 1'b0));
      push_request(pixel_request(-7, 1'b0));
      push_request(flush_request());
      settle();
      write_register(CSR_FRAME_WIDTH, 32'd1);
      write_register(CSR_FRAME_HEIGHT, 32'd4);
      push_random_frame(1, 4, 100, sent);
      settle();
      write_register(CSR_FRAME_WIDTH, 32'd5);
      write_register(CSR_FRAME_HEIGHT, 32'd0);
      push_random_frame(5, 1, 100, sent);
      settle();
   endtask

   // Oversize width and height clamp to the line store size and the row limit;
   // send only the opening of each frame.
   task automatic test_size_clamps();
      int sent;
      set_traffic(0, 0);
      write_register(CSR_COST_SHAPE, {31'd0, SHAPE_ABS_DIFF});
      write_register(CSR_FRAME_WIDTH, 32'h0000_1FFF);
      write_register(CSR_FRAME_HEIGHT, 32'd1);
      push_random_frame(MAX_WIDTH, 1, CLAMP_ITEMS, sent);
      settle();
      set_traffic(27, 27);
      write_register(CSR_FRAME_WIDTH, 32'd1);
      write_register(CSR_FRAME_HEIGHT, 32'h0000_1FFF);
      push_random_frame(1, HEIGHT_LIMIT, CLAMP_ITEMS, sent);
      settle();
   endtask

   // Abandon a frame part way; a width or height write must restart the position,
   // while cost register writes take effect without a restart.
   task automatic test_frame_restart();
      int sent;
      set_traffic(27, 27);
      write_register(CSR_COST_SHAPE, {31'd0, SHAPE_SQUARED});
      write_register(CSR_FRAME_WIDTH, 32'd4);
      write_register(CSR_FRAME_HEIGHT, 32'd3);
      push_random_frame(4, 3, 7, sent);
      settle();
      write_register(CSR_BOUNDARY_COST, 32'h0000_0BAD);
      push_random_frame(4, 3, 3, sent);
      settle();
      write_register(CSR_FRAME_WIDTH, 32'd4);
      push_random_frame(4, 3, 100, sent);
      settle();
      push_random_frame(4, 3, 5, sent);
      settle();
      write_register(CSR_FRAME_HEIGHT, 32'd3);
      push_random_frame(4, 3, 100, sent);
      settle();
   endtask

   // Mostly whole frames with random content and sizes; some cut short, some
   // followed by stray requests that open a new frame.
   task automatic test_random_frames();
      int          frame, sent, items_done, cols, rows, variant, stop;
      logic [31:0] junk;
      logic [31:0] dim_value;
      frame      = 0;
      items_done = 0;
      while (items_done < RANDOM_ITEMS) begin
         case ((frame / 4) % 4)
            0: set_traffic(0, 0);
            1: set_traffic(52, 0);
            2: set_traffic(0, 52);
            default: set_traffic(27, 27);
         endcase
         cols = $urandom_range(1, 8);
         rows = $urandom_range(1, 6);
         if ($urandom_range(0, 9) == 0) begin
            cols = $urandom_range(9, 64);
            rows = $urandom_range(1, 3);
         end
         junk      = $urandom_range(0, 1) ? ($urandom & 32'hFFFF_E000) : 32'd0;
         dim_value = (cols == 1 && $urandom_range(0, 1)) ? 32'd0 : cols;
         write_register(CSR_FRAME_WIDTH, junk | dim_value);
         junk      = $urandom_range(0, 1) ? ($urandom & 32'hFFFF_E000) : 32'd0;
         dim_value = (rows == 1 && $urandom_range(0, 1)) ? 32'd0 : rows;
         write_register(CSR_FRAME_HEIGHT, junk | dim_value);
         case ($urandom_range(0, 3))
            0: write_register(CSR_BOUNDARY_COST, 32'd0);
            1: write_register(CSR_BOUNDARY_COST, 32'hFFFF_FFFF);
            default: write_register(CSR_BOUNDARY_COST, $urandom);
         endcase
         write_register(CSR_COST_SHAPE, $urandom);
         variant = $urandom_range(0, 9);
         stop    = (variant == 0) ? $urandom_range(1, cols * rows + cols)
                                  : cols * rows + cols + 1;
         push_random_frame(cols, rows, stop, sent);
         items_done += sent;
         if (variant == 1) begin
            push_random_frame(cols, rows, $urandom_range(1, cols + 2), sent);
            items_done += sent;
         end
         settle();
         frame++;
      end
   endtask

   task automatic note_mismatch(input string what, input logic [COST_BITS-1:0] want,
                                input logic [COST_BITS-1:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("result %0d: %s expected %0h, got %0h", result_index, what, want, got);
      end
   endtask

   // Compare every accepted result, label by label, against the oldest prediction.
   always @(posedge clock) begin : check_costs
      rsp_type                            want;
      logic [0:NUM_TAPS-1][COST_BITS-1:0] want_costs, got_costs;
      logic                               want_last, got_last;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_costs.size() == 0) begin
            note_mismatch("result with nothing pending", '0, '0);
         end else begin
            want = pending_costs.pop_front();
            {want_costs, want_last} = want;
            {got_costs, got_last}   = rsp_data;
            for (int k = 0; k < NUM_TAPS; k++) begin
               if (got_costs[k] !== want_costs[k]) begin
                  note_mismatch($sformatf("label %0d cost", k), want_costs[k], got_costs[k]);
               end
            end
            if (got_last !== want_last) begin
               note_mismatch("last_of_frame", {31'd0, want_last}, {31'd0, got_last});
            end
         end
         result_index++;
      end
   end

   // Hard limit on the run; a hang anywhere ends here.
   initial begin
      #(TIMEOUT_UNITS);
      $display("simulation failed");
      $finish;
   end

   initial begin
      foreach (sample_history[i]) sample_history[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_costs();
      test_elevation_extremes();
      test_absolute_shape();
      test_degenerate_sizes();
      test_size_clamps();
      test_frame_restart();
      test_random_frames();
      settle();
      if (mismatch_count == 0 && pending_costs.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
